// ===== hdl/wgo_pkg.sv =====
// Shared types and constants for the waveform operator with gain and offset.
`default_nettype none
package wgo_pkg;
	localparam int DATA_W = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int REG_IDX_W = 2;

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_MUL  = 3'd2,
		OP_DIV  = 3'd3,
		OP_ABS  = 3'd4,
		OP_SQRT = 3'd5,
		OP_NEG  = 3'd6
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_INACTIVE = 3'd1,
		ST_DIVZERO  = 3'd2,
		ST_NEGROOT  = 3'd3,
		ST_SAT      = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		K_PASS = 2'd0,
		K_DIV  = 2'd1,
		K_ROOT = 2'd2
	} kind_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_OP     = 2'd0,
		REG_GAIN   = 2'd1,
		REG_OFFSET = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic    valid;
		status_t status;
		logic    neg;
		kind_t   kind;
	} ctl_t;

	typedef struct packed {
		logic              active;
		logic [DATA_W-1:0] first_value;
		logic [DATA_W-1:0] second_value;
	} in_t;

	typedef struct packed {
		logic [DATA_W-1:0] result;
		status_t           status;
	} out_t;
endpackage
`default_nettype wire

// ===== hdl/wgo_front.sv =====
// Input stage: operator decode, add, subtract, multiply, sign handling and chain set-up.
`default_nettype none
module wgo_front import wgo_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire in_t                         in_item,
	input  wire logic [2:0]                  op_sel,
	output ctl_t                             ctl_s1,
	output logic [2*DATA_W-1:0]              mag_s1,
	output logic [DATA_W+FRAC_BITS-1:0]      nq_s1,
	output logic [DATA_W-1:0]                div_s1,
	output logic [2*((DATA_W+FRAC_BITS+1)/2)-1:0] rad_s1
);
	localparam int W = DATA_W;
	localparam int F = FRAC_BITS;
	localparam int MW = 2 * W;
	localparam int NW = W + F;
	localparam int R = (W + F + 1) / 2;

	logic          a_neg, b_neg;
	logic [W-1:0]  a_mag, b_mag;
	logic [W:0]    sum;
	logic [W:0]    sum_mag;
	logic [MW-1:0] prod;
	ctl_t          ctl_d;
	logic [MW-1:0] mag_d;
	logic [2*R-1:0] rad_d;

	always_comb begin
		a_neg = in_item.first_value[W-1];
		b_neg = in_item.second_value[W-1];
		a_mag = a_neg ? (W'(0) - in_item.first_value) : in_item.first_value;
		b_mag = b_neg ? (W'(0) - in_item.second_value) : in_item.second_value;
		if (op_sel == OP_SUB) begin
			sum = {in_item.first_value[W-1], in_item.first_value}
				- {in_item.second_value[W-1], in_item.second_value};
		end else begin
			sum = {in_item.first_value[W-1], in_item.first_value}
				+ {in_item.second_value[W-1], in_item.second_value};
		end
		sum_mag = sum[W] ? ((W+1)'(0) - sum) : sum;
		prod = MW'(a_mag) * MW'(b_mag);
		rad_d = '0;
		rad_d[NW-1:0] = {a_mag, {F{1'b0}}};

		ctl_d.valid = start;
		ctl_d.status = ST_OK;
		ctl_d.neg = 1'b0;
		ctl_d.kind = K_PASS;
		mag_d = '0;
		case (op_sel)
			OP_ADD, OP_SUB: begin
				ctl_d.neg = sum[W];
				mag_d = MW'(sum_mag);
			end
			OP_MUL: begin
				ctl_d.neg = a_neg ^ b_neg;
				mag_d = prod >> F;
			end
			OP_DIV: begin
				ctl_d.neg = a_neg ^ b_neg;
				ctl_d.kind = K_DIV;
				if (b_mag == '0) ctl_d.status = ST_DIVZERO;
			end
			OP_ABS: begin
				mag_d = MW'(a_mag);
			end
			OP_SQRT: begin
				ctl_d.kind = K_ROOT;
				if (a_neg) ctl_d.status = ST_NEGROOT;
			end
			OP_NEG: begin
				ctl_d.neg = ~a_neg;
				mag_d = MW'(a_mag);
			end
			default: begin
				mag_d = '0;
			end
		endcase
		if (!in_item.active) ctl_d.status = ST_INACTIVE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_d;
		end
	end

	always_ff @(posedge clk) begin
		mag_s1 <= mag_d;
		nq_s1  <= {a_mag, {F{1'b0}}};
		div_s1 <= b_mag;
		rad_s1 <= rad_d;
	end
endmodule
`default_nettype wire

// ===== hdl/wgo_cell.sv =====
// One cell of the chain: one restoring divide step and, in the first R cells, one square-root digit step.
`default_nettype none
module wgo_cell import wgo_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int IDX = 0
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire ctl_t                         ctl_i,
	input  wire logic [2*DATA_W-1:0]          mag_i,
	input  wire logic [DATA_W+FRAC_BITS-1:0]  nq_i,
	input  wire logic [DATA_W-1:0]            rem_i,
	input  wire logic [DATA_W-1:0]            div_i,
	input  wire logic [2*((DATA_W+FRAC_BITS+1)/2)-1:0] rad_i,
	input  wire logic [(DATA_W+FRAC_BITS+1)/2+1:0]     rrem_i,
	input  wire logic [(DATA_W+FRAC_BITS+1)/2-1:0]     root_i,
	output ctl_t                              ctl_q,
	output logic [2*DATA_W-1:0]               mag_q,
	output logic [DATA_W+FRAC_BITS-1:0]       nq_q,
	output logic [DATA_W-1:0]                 rem_q,
	output logic [DATA_W-1:0]                 div_q,
	output logic [2*((DATA_W+FRAC_BITS+1)/2)-1:0] rad_q,
	output logic [(DATA_W+FRAC_BITS+1)/2+1:0]     rrem_q,
	output logic [(DATA_W+FRAC_BITS+1)/2-1:0]     root_q
);
	localparam int W = DATA_W;
	localparam int NW = W + FRAC_BITS;
	localparam int R = (W + FRAC_BITS + 1) / 2;
	localparam int RW = R + 2;

	logic [W:0]    part;
	logic          q_bit;
	logic [W:0]    diff;
	logic [NW-1:0] nq_d;
	logic [W-1:0]  rem_d;
	logic [2*R-1:0] rad_d;
	logic [RW-1:0] rrem_d;
	logic [R-1:0]  root_d;

	always_comb begin
		part  = {rem_i, nq_i[NW-1]};
		q_bit = part >= {1'b0, div_i};
		diff  = part - {1'b0, div_i};
		rem_d = q_bit ? diff[W-1:0] : part[W-1:0];
		nq_d  = {nq_i[NW-2:0], q_bit};
	end

	generate
		if (IDX < R) begin : g_root
			logic [RW-1:0] rr;
			logic [RW-1:0] trial;
			logic          r_bit;
			always_comb begin
				rr     = {rrem_i[RW-3:0], rad_i[2*R-1 -: 2]};
				trial  = {root_i, 2'b01};
				r_bit  = rr >= trial;
				rrem_d = r_bit ? (rr - trial) : rr;
				root_d = {root_i[R-2:0], r_bit};
				rad_d  = {rad_i[2*R-3:0], 2'b00};
			end
		end else begin : g_hold
			always_comb begin
				rrem_d = rrem_i;
				root_d = root_i;
				rad_d  = rad_i;
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		mag_q  <= mag_i;
		nq_q   <= nq_d;
		rem_q  <= rem_d;
		div_q  <= div_i;
		rad_q  <= rad_d;
		rrem_q <= rrem_d;
		root_q <= root_d;
	end
endmodule
`default_nettype wire

// ===== hdl/wgo_back.sv =====
// Output stages: operator saturation, gain multiply, offset add and status.
`default_nettype none
module wgo_back import wgo_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire ctl_t                         ctl_i,
	input  wire logic [2*DATA_W-1:0]          mag_i,
	input  wire logic [DATA_W+FRAC_BITS-1:0]  quot_i,
	input  wire logic [(DATA_W+FRAC_BITS+1)/2-1:0] root_i,
	input  wire logic [DATA_W-1:0]            gain,
	input  wire logic [DATA_W-1:0]            offset,
	output logic                              done,
	output out_t                              out_item
);
	localparam int W = DATA_W;
	localparam int MW = 2 * W;

	function automatic logic [W+1:0] clamp(input logic neg, input logic [MW-1:0] mag);
		logic [MW-1:0] lim;
		logic          sat;
		logic [W-1:0]  m;
		lim = neg ? (MW'(1) << (W - 1)) : ((MW'(1) << (W - 1)) - MW'(1));
		sat = mag > lim;
		m = sat ? lim[W-1:0] : mag[W-1:0];
		return {sat, neg & (m != '0), m};
	endfunction

	ctl_t           ctl_s2, ctl_s3, ctl_s4;
	logic           sat_s2, sat_s3, sat_s4;
	logic           neg_s2;
	logic [W-1:0]   mag_s2;
	logic [MW-1:0]  prod_s3;
	logic           pneg_s3;
	logic [W-1:0]   val_s4;
	logic [MW-1:0]  sel_mag;
	logic [W+1:0]   c_op, c_gain;
	logic           g_neg;
	logic [W-1:0]   g_mag;
	logic [W:0]     sum;
	logic           sum_sat;
	logic [W-1:0]   sum_val;
	out_t           out_d;

	always_comb begin
		unique case (ctl_i.kind)
			K_DIV:   sel_mag = MW'(quot_i);
			K_ROOT:  sel_mag = MW'(root_i);
			default: sel_mag = mag_i;
		endcase
		c_op = clamp(ctl_i.neg, sel_mag);
		g_neg = gain[W-1];
		g_mag = g_neg ? (W'(0) - gain) : gain;
		c_gain = clamp(pneg_s3, prod_s3 >> FRAC_BITS);
		sum = {val_s4[W-1], val_s4} + {offset[W-1], offset};
		sum_sat = sum[W] != sum[W-1];
		if (sum_sat) begin
			sum_val = sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		end else begin
			sum_val = sum[W-1:0];
		end
		out_d.result = '0;
		out_d.status = ctl_s4.status;
		if (ctl_s4.status == ST_OK) begin
			out_d.result = sum_val;
			out_d.status = (sat_s4 || sum_sat) ? ST_SAT : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			done   <= 1'b0;
		end else begin
			ctl_s2 <= ctl_i;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			done   <= ctl_s4.valid;
		end
	end

	always_ff @(posedge clk) begin
		sat_s2   <= c_op[W+1];
		neg_s2   <= c_op[W];
		mag_s2   <= c_op[W-1:0];
		sat_s3   <= sat_s2;
		prod_s3  <= MW'(mag_s2) * MW'(g_mag);
		pneg_s3  <= neg_s2 ^ g_neg;
		sat_s4   <= sat_s3 | c_gain[W+1];
		val_s4   <= c_gain[W] ? (W'(0) - c_gain[W-1:0]) : c_gain[W-1:0];
		out_item <= out_d;
	end
endmodule
`default_nettype wire

// ===== hdl/waveform_operator_gain_offset.sv =====
// Pipeline: front stage, divide and square-root chain, then back stages; data is Q16.16 by default.
// Throughput: one transaction per cycle; busy is never raised.
// The latency is set by the divide chain, one quotient bit per cell.
// The receiver cannot stall; each result shows on done for one cycle.
// Reset clears the registers to operator add, gain 1.0, offset 0 and empties the pipeline.
`default_nettype none
module waveform_operator_gain_offset import wgo_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire in_t                  in_item,
	output logic                      done,
	output out_t                      out_item,
	input  wire logic                 wr_en,
	input  wire logic [REG_IDX_W-1:0] wr_index,
	input  wire logic [DATA_W-1:0]    wr_data
);
	localparam int W = DATA_W;
	localparam int L = W + FRAC_BITS;
	localparam int R = (W + FRAC_BITS + 1) / 2;

	logic [2:0]   op_q;
	logic [W-1:0] gain_q;
	logic [W-1:0] offset_q;

	ctl_t           ctl   [0:L];
	logic [2*W-1:0] mag   [0:L];
	logic [L-1:0]   nq    [0:L];
	logic [W-1:0]   rem   [0:L];
	logic [W-1:0]   dv    [0:L];
	logic [2*R-1:0] rad   [0:L];
	logic [R+1:0]   rrem  [0:L];
	logic [R-1:0]   root  [0:L];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q     <= OP_ADD;
			gain_q   <= W'(1) << FRAC_BITS;
			offset_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_OP:     op_q     <= wr_data[2:0];
				REG_GAIN:   gain_q   <= wr_data;
				REG_OFFSET: offset_q <= wr_data;
				default:    ;
			endcase
		end
	end

	wgo_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.in_item (in_item),
		.op_sel  (op_q),
		.ctl_s1  (ctl[0]),
		.mag_s1  (mag[0]),
		.nq_s1   (nq[0]),
		.div_s1  (dv[0]),
		.rad_s1  (rad[0])
	);

	assign rem[0]  = '0;
	assign rrem[0] = '0;
	assign root[0] = '0;

	generate
		for (genvar k = 0; k < L; k++) begin : g_chain
			wgo_cell #(.FRAC_BITS(FRAC_BITS), .IDX(k)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl_i  (ctl[k]),
				.mag_i  (mag[k]),
				.nq_i   (nq[k]),
				.rem_i  (rem[k]),
				.div_i  (dv[k]),
				.rad_i  (rad[k]),
				.rrem_i (rrem[k]),
				.root_i (root[k]),
				.ctl_q  (ctl[k+1]),
				.mag_q  (mag[k+1]),
				.nq_q   (nq[k+1]),
				.rem_q  (rem[k+1]),
				.div_q  (dv[k+1]),
				.rad_q  (rad[k+1]),
				.rrem_q (rrem[k+1]),
				.root_q (root[k+1])
			);
		end
	endgenerate

	wgo_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_i    (ctl[L]),
		.mag_i    (mag[L]),
		.quot_i   (nq[L]),
		.root_i   (root[L]),
		.gain     (gain_q),
		.offset   (offset_q),
		.done     (done),
		.out_item (out_item)
	);
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking bench for the waveform operator: random samples, operators and gain/offset.
`default_nettype none
module tb_top;
	import wgo_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam int LATENCY = DATA_W + FB + 5;
	localparam logic [DATA_W-1:0] MAXP = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] MINN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic [DATA_W-1:0] ONE = 1 << FB;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_t in_item = '0;
	logic done;
	out_t out_item;
	logic wr_en = 1'b0;
	logic [REG_IDX_W-1:0] wr_index = '0;
	logic [DATA_W-1:0] wr_data = '0;

	waveform_operator_gain_offset uut (.*);

	always #4 clk = ~clk;

	logic [2:0] cur_op;
	logic signed [DATA_W-1:0] cur_gain, cur_offset;
	in_t sample_q[$];
	out_t expected_q[$];
	int errors = 0;
	int gap = 0;
	bit feed_done = 0;

	task automatic report(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	// saturate a wide signed value and flag the clamp
	function automatic logic [DATA_W-1:0] clip(logic signed [127:0] v, ref bit sat);
		if (v > $signed({96'd0, MAXP})) begin
			sat = 1;
			return MAXP;
		end
		if (v < -$signed({95'd0, 1'b1, {(DATA_W-1){1'b0}}})) begin
			sat = 1;
			return MINN;
		end
		return v[DATA_W-1:0];
	endfunction

	function automatic logic signed [127:0] fx_product(logic signed [127:0] a, logic signed [127:0] b);
		logic signed [127:0] p;
		logic [127:0] m;
		p = a * b;
		m = p < 0 ? -p : p;
		m = m >> FB;
		return p < 0 ? -$signed(m) : $signed(m);
	endfunction

	function automatic out_t predict_sample(in_t s);
		out_t o;
		logic signed [127:0] a, b, r;
		logic [127:0] ma, mb, q, n, root;
		bit sat;
		sat = 0;
		o.result = '0;
		a = $signed(s.first_value);
		b = $signed(s.second_value);
		if (!s.active) begin
			o.status = ST_INACTIVE;
			return o;
		end
		r = 0;
		case (cur_op)
			OP_ADD: r = a + b;
			OP_SUB: r = a - b;
			OP_MUL: r = fx_product(a, b);
			OP_DIV: begin
				if (b == 0) begin
					o.status = ST_DIVZERO;
					return o;
				end
				ma = a < 0 ? -a : a;
				mb = b < 0 ? -b : b;
				q = (ma << FB) / mb;
				r = ((a < 0) != (b < 0)) ? -$signed(q) : $signed(q);
			end
			OP_ABS: r = a < 0 ? -a : a;
			OP_SQRT: begin
				if (a < 0) begin
					o.status = ST_NEGROOT;
					return o;
				end
				n = a << FB;
				root = 0;
				for (int i = 40; i >= 0; i--)
					if ((root | (128'd1 << i)) * (root | (128'd1 << i)) <= n)
						root |= 128'd1 << i;
				r = $signed(root);
			end
			OP_NEG: r = -a;
			default: r = 0;
		endcase
		r = $signed(clip(r, sat));
		r = $signed(clip(fx_product(r, cur_gain), sat));
		o.result = clip(r + cur_offset, sat);
		o.status = sat ? ST_SAT : ST_OK;
		return o;
	endfunction

	always @(negedge clk) begin
		if (start && !busy)
			expected_q.push_back(predict_sample(in_item));
		if (gap > 0) begin
			gap <= gap - 1;
			start <= 1'b0;
		end else if (sample_q.size() > 0 && !(start && busy)) begin
			in_item <= sample_q.pop_front();
			start <= 1'b1;
			gap <= $urandom_range(0, 3) == 0 ? $urandom_range(0, 12) : 0;
		end else if (!(start && busy)) begin
			start <= 1'b0;
		end
	end

	always @(posedge clk) begin
		out_t want;
		if (done) begin
			if (expected_q.size() == 0) begin
				report("unexpected transaction", out_item.result, '0);
			end else begin
				want = expected_q.pop_front();
				if (out_item.result !== want.result)
					report("result", out_item.result, want.result);
				if (out_item.status !== want.status)
					report("status", DATA_W'(out_item.status), DATA_W'(want.status));
			end
		end
	end

	function automatic logic [DATA_W-1:0] rand_value();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 3) == 0 ? MAXP : MINN;
			1: return $urandom_range(0, 8);
			2: return -$signed($urandom_range(0, 8));
			3: return $urandom_range(0, 1) ? $urandom_range(0, 4 * ONE) : -$urandom_range(0, 4 * ONE);
			default: return $urandom;
		endcase
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] val);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic apply_settings(logic [2:0] op, logic [DATA_W-1:0] g, logic [DATA_W-1:0] off);
		wait (sample_q.size() == 0 && !start);
		wait (expected_q.size() == 0);
		repeat (LATENCY + 4) @(negedge clk);
		write_reg(REG_OP, DATA_W'(op));
		write_reg(REG_GAIN, g);
		write_reg(REG_OFFSET, off);
		cur_op = op;
		cur_gain = g;
		cur_offset = off;
	endtask

	task automatic queue_sample(logic act, logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
		in_t s;
		s.active = act;
		s.first_value = a;
		s.second_value = b;
		sample_q.push_back(s);
	endtask

	initial begin
		logic [DATA_W-1:0] g, off;
		cur_op = OP_ADD;
		cur_gain = ONE;
		cur_offset = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// reset settings first, then every operator with plain gain
		queue_sample(1'b0, MAXP, MAXP);
		queue_sample(1'b1, MAXP, MAXP);
		queue_sample(1'b1, MINN, MINN);
		queue_sample(1'b1, ONE, ONE);
		for (int op = 0; op < 8; op++) begin
			apply_settings(3'(op), ONE, 0);
			queue_sample(1'b1, MINN, 0);
			queue_sample(1'b1, MAXP, MINN);
			queue_sample(1'b1, 0, ONE);
			queue_sample(1'b1, -ONE, 3);
		end
		apply_settings(OP_MUL, MAXP, MINN);
		queue_sample(1'b1, ONE, ONE);
		queue_sample(1'b1, 0, 0);
		apply_settings(OP_ADD, MINN, MAXP);
		queue_sample(1'b1, ONE, 0);
		queue_sample(1'b1, 0, 0);
		for (int phase = 0; phase < 30; phase++) begin
			case ($urandom_range(0, 3))
				0: g = ONE;
				1: g = rand_value();
				2: g = $urandom_range(0, 1) ? MAXP : MINN;
				default: g = $urandom_range(0, 1) ? $urandom_range(0, 4 * ONE) : -$urandom_range(0, 4 * ONE);
			endcase
			off = $urandom_range(0, 2) == 0 ? 0 : rand_value();
			apply_settings(3'($urandom_range(0, 7)), g, off);
			for (int i = 0; i < 60; i++)
				queue_sample($urandom_range(0, 9) != 0, rand_value(), rand_value());
		end
		wait (sample_q.size() == 0 && !start);
		wait (expected_q.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

	initial begin
		#3000000;
		$display("tb_top failed");
		$finish;
	end
endmodule
`default_nettype wire
